### rtl/dhcp_tlv_pkg.sv
// ============================================================================
// DHCP option store editor - shared definitions
// Store geometry, pointer widths, request and status codes, and the
// request bundle that drives the option byte memory.
// ============================================================================
package dhcp_tlv_pkg;

  // Size of the option byte store in bytes.
  localparam int unsigned OPTION_BYTES = 312;

  // Address of one stored byte.
  localparam int unsigned AddrW = $clog2(OPTION_BYTES);
  // Pointer that can also hold the store size itself.
  localparam int unsigned PtrW = $clog2(OPTION_BYTES + 1);
  // Entry end position: a pointer plus the largest entry size of 257 bytes.
  localparam int unsigned PosW = $clog2(OPTION_BYTES + 258);

  // Filler byte for unused space and the end-of-options marker.
  localparam logic [7:0] FILLER = 8'hFF;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_SET_TAG = 2'd1,
    REQ_DATA    = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_BAD_TAG      = 2'd1,
    STAT_NO_ROOM      = 2'd2,
    STAT_NOT_EXPECTED = 2'd3
  } status_e;

  // One write port and one read port on the option byte memory.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/dhcp_option_tlv_editor_unit.sv
// ============================================================================
// DHCP option TLV editor
// Edits a store of DHCP options kept as tag-length-value entries, with a
// sequencer that scans and compacts the byte store in place.
// ============================================================================
// Usage. A request is taken at a rising clock edge where start_i is high and
// busy_o is low; req_type_i selects clear, set-tag header, data byte or read.
// Every request produces exactly one result: done_o is high for a single
// cycle while status_o, read_data_o and awaiting_data_o carry it. The
// receiver cannot stall, so the result must be captured in that cycle.
//
// Operation. A data byte is a write through the single write port of the
// byte memory, and a read goes through its registered read port. A clear
// sweeps the store, one byte per cycle. A set-tag header walks the store
// entry by entry, reading each entry header, and while earlier entries
// have been removed it copies each kept entry down before it opens the new
// entry. busy_o stays high for the whole operation, and the next request can
// be taken in the cycle the result is shown.
//
// Reset. After rst_ni is released the block fills the store with 255, one
// byte per cycle, over all OPTION_BYTES bytes with busy_o high. That pass
// gives no result transfer.
// ============================================================================
module dhcp_option_tlv_editor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] tag_i,
  input  logic [7:0] length_i,
  input  logic [7:0] data_byte_i,
  input  logic [8:0] index_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [7:0] read_data_o,
  output logic       awaiting_data_o
);
  import dhcp_tlv_pkg::*;

  localparam int unsigned SumW = PosW + 1;
  localparam logic [PtrW-1:0] NPtr = PtrW'(OPTION_BYTES);
  localparam logic [PosW-1:0] NPos = PosW'(OPTION_BYTES);

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_RD      = 4'd2;
  localparam logic [3:0] S_HDR0    = 4'd3;
  localparam logic [3:0] S_HDR1    = 4'd4;
  localparam logic [3:0] S_HDR2    = 4'd5;
  localparam logic [3:0] S_CPR     = 4'd6;
  localparam logic [3:0] S_CPW     = 4'd7;
  localparam logic [3:0] S_NEW     = 4'd8;
  localparam logic [3:0] S_NEW_LEN = 4'd9;

  // The scan compacts the store in place. v_q is the position in the edited
  // store and rd_q the position in the original contents that maps to it;
  // their gap is the number of bytes removed so far. rd_q saturates at the
  // store size, where every byte reads as filler.
  logic [3:0]      state_q, state_d;
  logic [PtrW-1:0] v_q, v_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [8:0]      ecnt_q, ecnt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      tag_q, tag_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      etag_q, etag_d;
  logic [PtrW-1:0] wp_q, wp_d;
  logic [7:0]      brem_q, brem_d;
  logic            tail_q, tail_d;
  logic            report_q, report_d;
  logic            done_q, done_d;
  logic [1:0]      status_q, status_d;
  logic [7:0]      rdata_q, rdata_d;

  mem_req_t        mem_req;
  logic [7:0]      mem_rdata;

  logic            accept;
  logic            v_last;
  logic            rd_last;
  logic            ent_handle;
  logic [7:0]      ent_tag;
  logic [7:0]      ent_len;
  logic [8:0]      ent_size;
  logic [PosW-1:0] end_pos;
  logic [PosW-1:0] rd_plus;
  logic [PtrW-1:0] rd_sat;
  logic [SumW-1:0] fit_sum;

  dhcp_tlv_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign accept = start_i && (state_q == S_IDLE);

  // The tag byte comes straight from the memory in S_HDR1 and was kept for
  // S_HDR2. A tag on the last byte has length zero; a length byte beyond
  // the original contents is filler.
  assign v_last   = (PosW'(v_q) + PosW'(1)) >= NPos;
  assign rd_last  = (PosW'(rd_q) + PosW'(1)) >= NPos;
  assign ent_tag  = (state_q == S_HDR1) ? mem_rdata : etag_q;
  assign ent_len  = (state_q == S_HDR2) ? mem_rdata : (v_last ? 8'h00 : FILLER);
  assign ent_size = 9'(ent_len) + 9'd2;
  assign end_pos  = PosW'(v_q) + PosW'(ent_size);
  assign rd_plus  = PosW'(rd_q) + PosW'(ent_size);
  assign rd_sat   = (rd_plus >= NPos) ? NPtr : PtrW'(rd_plus);
  assign fit_sum  = SumW'(pos_q) + SumW'(len_q) + SumW'(2);

  always_comb begin
    state_d    = state_q;
    v_d        = v_q;
    rd_d       = rd_q;
    ecnt_d     = ecnt_q;
    pos_d      = pos_q;
    tag_d      = tag_q;
    len_d      = len_q;
    etag_d     = etag_q;
    wp_d       = wp_q;
    brem_d     = brem_q;
    tail_d     = tail_q;
    report_d   = report_q;
    done_d     = 1'b0;
    status_d   = STAT_OK;
    rdata_d    = 8'h00;
    mem_req    = '0;
    ent_handle = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_CLEAR: begin
              brem_d   = 8'h00;
              v_d      = '0;
              report_d = 1'b1;
              state_d  = S_CLR;
            end
            REQ_SET_TAG: begin
              // Any header ends the wait for data bytes.
              brem_d = 8'h00;
              if (tag_i == 8'h00 || tag_i == FILLER) begin
                done_d   = 1'b1;
                status_d = STAT_BAD_TAG;
              end else begin
                tag_d   = tag_i;
                len_d   = length_i;
                v_d     = '0;
                rd_d    = '0;
                state_d = S_HDR0;
              end
            end
            REQ_DATA: begin
              done_d = 1'b1;
              if (brem_q == 8'h00 || wp_q >= NPtr) begin
                status_d = STAT_NOT_EXPECTED;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = AddrW'(wp_q);
                mem_req.wdata = data_byte_i;
                wp_d          = wp_q + 1'b1;
                brem_d        = brem_q - 1'b1;
              end
            end
            REQ_READ: begin
              if (PosW'(index_i) < NPos) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = AddrW'(index_i);
                state_d       = S_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = AddrW'(v_q);
        mem_req.wdata = FILLER;
        if (v_q == NPtr - 1'b1) begin
          done_d  = report_q;
          state_d = S_IDLE;
        end else begin
          v_d = v_q + 1'b1;
        end
      end

      S_RD: begin
        done_d  = 1'b1;
        rdata_d = mem_rdata;
        state_d = S_IDLE;
      end

      S_HDR0: begin
        if (v_q == NPtr || rd_q == NPtr) begin
          // End of store or only filler left: the scan stops here.
          pos_d   = PosW'(v_q);
          tail_d  = 1'b1;
          state_d = S_CPR;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AddrW'(rd_q);
          state_d       = S_HDR1;
        end
      end

      S_HDR1: begin
        etag_d = mem_rdata;
        if (mem_rdata == FILLER) begin
          pos_d   = PosW'(v_q);
          tail_d  = 1'b1;
          state_d = S_CPR;
        end else if (v_last || rd_last) begin
          ent_handle = 1'b1;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AddrW'(rd_q + 1'b1);
          state_d       = S_HDR2;
        end
      end

      S_HDR2: begin
        ent_handle = 1'b1;
      end

      // Moves bytes down by the removed amount: either a whole kept entry with its
      // header, or in tail mode everything up to the end of the store.
      S_CPR: begin
        if (v_q == NPtr) begin
          state_d = S_NEW;
        end else if (!tail_q && ecnt_q == 9'd0) begin
          state_d = S_HDR0;
        end else if (tail_q && rd_q == v_q) begin
          state_d = S_NEW;
        end else if (rd_q == NPtr) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = AddrW'(v_q);
          mem_req.wdata = FILLER;
          v_d           = v_q + 1'b1;
          if (!tail_q) begin
            ecnt_d = ecnt_q - 1'b1;
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = AddrW'(rd_q);
          state_d       = S_CPW;
        end
      end

      S_CPW: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = AddrW'(v_q);
        mem_req.wdata = mem_rdata;
        v_d           = v_q + 1'b1;
        rd_d          = rd_q + 1'b1;
        if (!tail_q) begin
          ecnt_d = ecnt_q - 1'b1;
        end
        state_d = S_CPR;
      end

      S_NEW: begin
        if (len_q == 8'h00) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (fit_sum > SumW'(OPTION_BYTES)) begin
          done_d   = 1'b1;
          status_d = STAT_NO_ROOM;
          state_d  = S_IDLE;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = AddrW'(pos_q);
          mem_req.wdata = tag_q;
          state_d       = S_NEW_LEN;
        end
      end

      S_NEW_LEN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = AddrW'(pos_q + PosW'(1));
        mem_req.wdata = len_q;
        wp_d          = PtrW'(pos_q + PosW'(2));
        brem_d        = len_q;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Outcome of one entry header. A matching entry is dropped by moving the
    // original-side pointer past it. A kept entry needs no moves while nothing
    // has been removed yet; otherwise its bytes are copied down.
    if (ent_handle) begin
      if (ent_tag == tag_q) begin
        rd_d    = rd_sat;
        state_d = S_HDR0;
      end else if (rd_q == v_q) begin
        if (end_pos >= NPos) begin
          pos_d   = end_pos;
          state_d = S_NEW;
        end else begin
          v_d     = PtrW'(end_pos);
          rd_d    = PtrW'(end_pos);
          state_d = S_HDR0;
        end
      end else begin
        ecnt_d  = ent_size;
        pos_d   = end_pos;
        tail_d  = 1'b0;
        state_d = S_CPR;
      end
    end
  end

  // Control state. Reset starts the filler pass over the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      v_q      <= '0;
      rd_q     <= '0;
      ecnt_q   <= '0;
      pos_q    <= '0;
      wp_q     <= '0;
      brem_q   <= 8'h00;
      tail_q   <= 1'b0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      v_q      <= v_d;
      rd_q     <= rd_d;
      ecnt_q   <= ecnt_d;
      pos_q    <= pos_d;
      wp_q     <= wp_d;
      brem_q   <= brem_d;
      tail_q   <= tail_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    len_q    <= len_d;
    etag_q   <= etag_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_data_o     = rdata_q;
  assign awaiting_data_o = (brem_q != 8'h00);

endmodule

### rtl/dhcp_tlv_store.sv
// ============================================================================
// DHCP option byte store
// Synchronous memory of OPTION_BYTES bytes with one write port and one
// read port; read data is registered and appears in the cycle after the read.
// ============================================================================
module dhcp_tlv_store (
  input  logic                  clk_i,
  input  dhcp_tlv_pkg::mem_req_t req_i,
  output logic [7:0]            rdata_o
);
  import dhcp_tlv_pkg::*;

  logic [7:0] mem_q [OPTION_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
